FILE: rtl/core/srat_pkg.sv
package srat_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int ADDR_BYTES = 6;
	localparam int RESET_RESULT_LIMIT = 32;
	localparam int ADDR_W = ADDR_BYTES * 8;
	localparam int REC_W = 32;
	localparam int AGE_W = 4;
	localparam int COUNT_W = 8;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_RESULT = 2'd1;
	localparam logic [1:0] OP_END = 2'd2;

	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_PASSIVE = 2'd1;
	localparam logic [1:0] MODE_ACTIVE = 2'd2;

	localparam logic [1:0] REG_AGE_START = 2'd0;
	localparam logic [1:0] REG_RESULT_LIMIT = 2'd1;

	localparam logic KIND_REPLAY = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [REC_W-1:0]  rec;
		logic [AGE_W-1:0]  age;
		logic              seen;
	} entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0] key;
		logic [REC_W-1:0]  rec;
		logic [AGE_W-1:0]  age_start;
		logic [OCC_W-1:0]  occ;
		logic              lookup;
		logic              clr_seen;
		logic              shift;
		logic              keep;
		logic              mark;
		logic [IDX_W-1:0]  wpos;
		entry_t            head;
	} ctl_t;

endpackage

FILE: rtl/core/srat_cell.sv
module srat_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [srat_pkg::IDX_W-1:0]  cell_idx,
	input  srat_pkg::ctl_t              ctl,
	input  logic                        append,
	input  srat_pkg::entry_t            nxt,
	input  logic                        found_in,
	output logic                        found_out,
	output srat_pkg::entry_t            ent
);

	srat_pkg::entry_t ent_q;
	srat_pkg::entry_t ent_d;
	logic [srat_pkg::ADDR_W-1:0] addr_q;
	logic [srat_pkg::REC_W-1:0]  rec_q;
	logic [srat_pkg::AGE_W-1:0]  age_q;
	logic                        seen_q;
	logic [srat_pkg::OCC_W-1:0] idx_ext;
	logic valid;
	logic hit;

	assign ent_q = {addr_q, rec_q, age_q, seen_q};
	assign idx_ext = srat_pkg::OCC_W'(cell_idx);
	assign valid = idx_ext < ctl.occ;
	assign hit = valid && (ent_q.addr == ctl.key);
	assign found_out = found_in | hit;
	assign ent = ent_q;

	always_comb begin
		ent_d = ent_q;
		if (ctl.clr_seen) begin
			ent_d.seen = 1'b0;
		end
		if (ctl.lookup && hit) begin
			ent_d.seen = 1'b1;
			if (!found_in) begin
				ent_d.rec = ctl.rec;
				ent_d.age = ctl.age_start;
			end
		end
		if (append && (idx_ext == ctl.occ)) begin
			ent_d.addr = ctl.key;
			ent_d.rec = ctl.rec;
			ent_d.age = ctl.age_start;
			ent_d.seen = 1'b1;
		end
		if (ctl.shift) begin
			// take the neighbor's entry, or the kept head at the write slot
			if (ctl.keep && (cell_idx == ctl.wpos)) begin
				ent_d = ctl.head;
			end else begin
				ent_d = nxt;
				if (ctl.mark && (nxt.addr == ctl.key)) begin
					ent_d.seen = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= ent_d.addr;
		rec_q <= ent_d.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
			seen_q <= 1'b0;
		end else begin
			age_q <= ent_d.age;
			seen_q <= ent_d.seen;
		end
	end

endmodule

FILE: rtl/core/scan_result_aging_table.sv
// Scan result aging table.
// Requests enter on start/busy: a request is taken at a clock edge where start
// is high and busy is low. Opcode selects begin of scan (with scan_mode), one
// scan result (bssid, record_word) or end of scan. Begin and result requests
// finish in the cycle they are taken; busy stays low, so one may follow every
// cycle. A passive result compares its BSSID against every entry at once.
// End of a passive scan walks the table one entry per cycle through the row
// of cells: the head cell is examined, the row shifts toward the head and a
// surviving entry is rewritten at the tail. An end request therefore keeps
// busy high in the walk and summary states; other modes report at once.
// Each replayed entry and the closing summary appear on the result ports for
// exactly one cycle, marked by result_valid, in the cycle after they are formed;
// the summary carries last. The receiver cannot stall.
// Registers age_start (index 0) and result_limit (index 1) are written over
// the cfg channel, which is always ready; writes to other indexes are ignored.
// Reset empties the table, selects pass-through mode and loads age_start 4 and
// result_limit 32. No clearing pass is needed after reset.
module scan_result_aging_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [1:0]                    scan_mode,
	input  logic [srat_pkg::ADDR_W-1:0]   bssid,
	input  logic [srat_pkg::REC_W-1:0]    record_word,
	output logic                          result_valid,
	output logic                          kind,
	output logic [srat_pkg::ADDR_W-1:0]   out_bssid,
	output logic [srat_pkg::REC_W-1:0]    out_record,
	output logic [srat_pkg::COUNT_W-1:0]  merged_count,
	output logic                          insert_dropped,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [7:0]                    cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SUM
	} state_t;

	localparam int D = srat_pkg::TABLE_DEPTH;

	state_t state_q;
	logic [srat_pkg::OCC_W-1:0]   occ_q;
	logic [srat_pkg::OCC_W-1:0]   nun_q;
	logic [srat_pkg::OCC_W-1:0]   kept_q;
	logic [1:0]                   mode_q;
	logic [srat_pkg::COUNT_W-1:0] cnt_q;
	logic [srat_pkg::COUNT_W-1:0] merge_q;
	logic                         drop_q;
	logic [srat_pkg::AGE_W-1:0]   age_start_q;
	logic [srat_pkg::COUNT_W-1:0] limit_q;

	srat_pkg::ctl_t   ctl;
	srat_pkg::entry_t ents  [D];
	srat_pkg::entry_t nxts  [D];
	logic             found [D+1];

	logic take;
	logic is_begin, is_item, is_end;
	logic passive_item, active_item, room;
	logic append;
	logic head_keep, head_replay;
	logic [srat_pkg::OCC_W-1:0] wpos_full;
	srat_pkg::entry_t head_new;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign take = start && !busy;
	assign is_begin = take && (opcode == srat_pkg::OP_BEGIN);
	assign is_item = take && (opcode == srat_pkg::OP_RESULT);
	assign is_end = take && (opcode == srat_pkg::OP_END);
	assign passive_item = is_item && (mode_q == srat_pkg::MODE_PASSIVE);
	assign active_item = is_item && (mode_q == srat_pkg::MODE_ACTIVE);
	assign room = occ_q < srat_pkg::OCC_W'(D);

	// append when a passive result matched no entry, or on any active result, if there is room
	assign append = room && ((passive_item && !found[D]) || active_item);

	// head of the row during the end pass
	assign head_keep = ents[0].seen || (ents[0].age > srat_pkg::AGE_W'(1));
	assign head_replay = !ents[0].seen && head_keep && (merge_q < limit_q);
	assign wpos_full = nun_q - srat_pkg::OCC_W'(1) + kept_q;

	always_comb begin
		head_new = ents[0];
		head_new.seen = 1'b0;
		if (!ents[0].seen) begin
			head_new.age = ents[0].age - srat_pkg::AGE_W'(1);
		end
	end

	always_comb begin
		ctl.key = (state_q == ST_WALK) ? ents[0].addr : bssid;
		ctl.rec = record_word;
		ctl.age_start = age_start_q;
		ctl.occ = occ_q;
		ctl.lookup = passive_item;
		ctl.clr_seen = is_begin || (state_q == ST_SUM)
			|| (is_end && (mode_q != srat_pkg::MODE_PASSIVE || occ_q == '0));
		ctl.shift = (state_q == ST_WALK);
		ctl.keep = head_keep;
		ctl.mark = head_replay;
		ctl.wpos = wpos_full[srat_pkg::IDX_W-1:0];
		ctl.head = head_new;
	end

	assign found[0] = 1'b0;

	for (genvar k = 0; k < D; k++) begin : g_cell
		if (k == D - 1) begin : g_tail
			assign nxts[k] = '0;
		end else begin : g_mid
			assign nxts[k] = ents[k+1];
		end
		srat_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (srat_pkg::IDX_W'(k)),
			.ctl       (ctl),
			.append    (append),
			.nxt       (nxts[k]),
			.found_in  (found[k]),
			.found_out (found[k+1]),
			.ent       (ents[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_start_q <= srat_pkg::AGE_W'(4);
			limit_q <= srat_pkg::COUNT_W'(srat_pkg::RESET_RESULT_LIMIT);
		end else if (cfg_valid) begin
			case (cfg_index)
				srat_pkg::REG_AGE_START:    age_start_q <= cfg_data[srat_pkg::AGE_W-1:0];
				srat_pkg::REG_RESULT_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q <= '0;
			nun_q <= '0;
			kept_q <= '0;
			mode_q <= srat_pkg::MODE_PASS;
			cnt_q <= '0;
			merge_q <= '0;
			drop_q <= 1'b0;
			result_valid <= 1'b0;
			kind <= srat_pkg::KIND_REPLAY;
			out_bssid <= '0;
			out_record <= '0;
			merged_count <= '0;
			insert_dropped <= 1'b0;
			last <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (is_begin) begin
						mode_q <= (scan_mode inside {srat_pkg::MODE_PASSIVE,
							srat_pkg::MODE_ACTIVE}) ? scan_mode
							: srat_pkg::MODE_PASS;
						cnt_q <= '0;
						drop_q <= 1'b0;
						if (scan_mode == srat_pkg::MODE_ACTIVE) begin
							occ_q <= '0;
						end
					end
					if (is_item) begin
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + srat_pkg::COUNT_W'(1);
						end
						if (append) begin
							occ_q <= occ_q + srat_pkg::OCC_W'(1);
						end else if (!room && (active_item || passive_item)
							&& (active_item || !found[D])) begin
							drop_q <= 1'b1;
						end
					end
					if (is_end) begin
						if (mode_q == srat_pkg::MODE_PASSIVE && occ_q != '0) begin
							state_q <= ST_WALK;
							nun_q <= occ_q;
							kept_q <= '0;
							merge_q <= cnt_q;
						end else begin
							// summary at once
							result_valid <= 1'b1;
							kind <= srat_pkg::KIND_SUMMARY;
							out_bssid <= '0;
							out_record <= '0;
							merged_count <= (mode_q == srat_pkg::MODE_ACTIVE)
								? srat_pkg::COUNT_W'(occ_q) : cnt_q;
							insert_dropped <= drop_q;
							last <= 1'b1;
							cnt_q <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				ST_WALK: begin
					nun_q <= nun_q - srat_pkg::OCC_W'(1);
					if (head_keep) begin
						kept_q <= kept_q + srat_pkg::OCC_W'(1);
					end
					if (head_replay) begin
						merge_q <= merge_q + srat_pkg::COUNT_W'(1);
						result_valid <= 1'b1;
						kind <= srat_pkg::KIND_REPLAY;
						out_bssid <= ents[0].addr;
						out_record <= ents[0].rec;
						merged_count <= '0;
						insert_dropped <= 1'b0;
						last <= 1'b0;
					end
					if (nun_q == srat_pkg::OCC_W'(1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// close the pass: shrink the table and report
					occ_q <= kept_q;
					result_valid <= 1'b1;
					kind <= srat_pkg::KIND_SUMMARY;
					out_bssid <= '0;
					out_record <= '0;
					merged_count <= merge_q;
					insert_dropped <= drop_q;
					last <= 1'b1;
					cnt_q <= '0;
					drop_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (nun_q != '0))
		else $error("end pass running with no entries left");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (kept_q + nun_q <= occ_q))
		else $error("kept and pending entries exceed occupancy");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (kind == last))
		else $error("last flag does not match result kind");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= srat_pkg::OCC_W'(D))
		else $error("occupancy beyond table depth");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

// Bench for the scan result aging table.
// A queue of pending requests, filled up front, feeds a driver that works at the
// falling edge. A monitor at the rising edge notes every accepted request and
// register write. It runs them through a local copy of the table to predict the
// replayed entries and summaries. It compares every strobed result with the
// oldest prediction.
module tb_top;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    opcode;
	logic [1:0]                    scan_mode;
	logic [srat_pkg::ADDR_W-1:0]   bssid;
	logic [srat_pkg::REC_W-1:0]    record_word;
	logic                          result_valid;
	logic                          kind;
	logic [srat_pkg::ADDR_W-1:0]   out_bssid;
	logic [srat_pkg::REC_W-1:0]    out_record;
	logic [srat_pkg::COUNT_W-1:0]  merged_count;
	logic                          insert_dropped;
	logic                          last;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index;
	logic [7:0]                    cfg_data;

	scan_result_aging_table u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .scan_mode(scan_mode), .bssid(bssid),
		.record_word(record_word), .result_valid(result_valid), .kind(kind),
		.out_bssid(out_bssid), .out_record(out_record),
		.merged_count(merged_count), .insert_dropped(insert_dropped),
		.last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// One entry of the stimulus queue: a request, a register write, or a pause
	// that holds the sender until every predicted result has come back.
	typedef enum int {PEND_REQ, PEND_CFG, PEND_DRAIN} pend_kind_t;

	typedef struct {
		pend_kind_t                   tag;
		logic [1:0]                   op;
		logic [1:0]                   mode;
		logic [srat_pkg::ADDR_W-1:0]  addr;
		logic [srat_pkg::REC_W-1:0]   rec;
		logic [1:0]                   ridx;
		logic [7:0]                   rdata;
	} pending_t;

	typedef struct packed {
		logic                         kind;
		logic [srat_pkg::ADDR_W-1:0]  addr;
		logic [srat_pkg::REC_W-1:0]   rec;
		logic [srat_pkg::COUNT_W-1:0] count;
		logic                         drop;
		logic                         last;
	} scan_report_t;

	pending_t                    pending[$];
	scan_report_t                expected_reports[$];
	logic [srat_pkg::ADDR_W-1:0] addr_pool[$];

	// Local copy of the table and its registers.
	logic [srat_pkg::ADDR_W-1:0] tbl_addr[srat_pkg::TABLE_DEPTH];
	logic [srat_pkg::REC_W-1:0]  tbl_rec[srat_pkg::TABLE_DEPTH];
	logic [srat_pkg::AGE_W-1:0]  tbl_age[srat_pkg::TABLE_DEPTH];
	logic                        tbl_seen[srat_pkg::TABLE_DEPTH];
	int                          tbl_occ;
	logic [1:0]                  cur_mode;
	int                          item_count;
	logic                        drop_pending;
	logic [srat_pkg::AGE_W-1:0]  age_start_reg;
	logic [7:0]                  limit_reg;

	int  mismatches;
	int  reports_checked;
	int  replays_seen;
	int  drops_seen;
	int  requests_taken;
	bit  req_taken;
	bit  cfg_taken;
	int  burst_left;
	int  gap_left;
	int  quiet_cycles;

	function automatic logic [srat_pkg::ADDR_W-1:0] rand_addr();
		return srat_pkg::ADDR_W'({$urandom(), $urandom()});
	endfunction

	// Store one result in the table; a full table sets the drop flag.
	task automatic store_entry(logic [srat_pkg::ADDR_W-1:0] a,
			logic [srat_pkg::REC_W-1:0] r);
		if (tbl_occ >= srat_pkg::TABLE_DEPTH) begin
			drop_pending = 1'b1;
		end else begin
			tbl_addr[tbl_occ] = a;
			tbl_rec[tbl_occ] = r;
			tbl_age[tbl_occ] = age_start_reg;
			tbl_seen[tbl_occ] = 1'b1;
			tbl_occ++;
		end
	endtask

	// Predict what one accepted request does to the table and what it reports.
	task automatic apply_scan_request(logic [1:0] op, logic [1:0] mode,
			logic [srat_pkg::ADDR_W-1:0] a, logic [srat_pkg::REC_W-1:0] r);
		bit           found;
		int           w;
		int           count;
		scan_report_t rep;
		case (op)
			srat_pkg::OP_BEGIN: begin
				cur_mode = (mode inside {srat_pkg::MODE_PASSIVE, srat_pkg::MODE_ACTIVE})
					? mode : srat_pkg::MODE_PASS;
				item_count = 0;
				drop_pending = 1'b0;
				foreach (tbl_seen[i]) tbl_seen[i] = 1'b0;
				if (cur_mode == srat_pkg::MODE_ACTIVE)
					tbl_occ = 0;
			end
			srat_pkg::OP_RESULT: begin
				if (item_count < 255)
					item_count++;
				if (cur_mode == srat_pkg::MODE_PASSIVE) begin
					found = 0;
					// Refresh the first match; every match counts as seen.
					for (int i = 0; i < tbl_occ; i++) begin
						if (tbl_addr[i] == a) begin
							if (!found) begin
								tbl_rec[i] = r;
								tbl_age[i] = age_start_reg;
								found = 1;
							end
							tbl_seen[i] = 1'b1;
						end
					end
					if (!found)
						store_entry(a, r);
				end else if (cur_mode == srat_pkg::MODE_ACTIVE) begin
					store_entry(a, r);
				end
			end
			srat_pkg::OP_END: begin
				count = item_count;
				if (cur_mode == srat_pkg::MODE_PASSIVE) begin
					w = 0;
					for (int i = 0; i < tbl_occ; i++) begin
						if (!tbl_seen[i]) begin
							// Drop an entry that ages out; close the gap behind it.
							if (tbl_age[i] <= 1)
								continue;
							tbl_age[i] = tbl_age[i] - 1'b1;
							if (count < limit_reg) begin
								rep = '{srat_pkg::KIND_REPLAY, tbl_addr[i], tbl_rec[i],
									'0, 1'b0, 1'b0};
								expected_reports.push_back(rep);
								count++;
								// Later duplicates of a replayed entry do not age.
								for (int j = i + 1; j < tbl_occ; j++)
									if (tbl_addr[j] == tbl_addr[i])
										tbl_seen[j] = 1'b1;
							end
						end
						tbl_addr[w] = tbl_addr[i];
						tbl_rec[w] = tbl_rec[i];
						tbl_age[w] = tbl_age[i];
						tbl_seen[w] = tbl_seen[i];
						w++;
					end
					tbl_occ = w;
				end else if (cur_mode == srat_pkg::MODE_ACTIVE) begin
					count = tbl_occ;
				end
				rep = '{srat_pkg::KIND_SUMMARY, '0, '0, count[srat_pkg::COUNT_W-1:0],
					drop_pending, 1'b1};
				expected_reports.push_back(rep);
				item_count = 0;
				drop_pending = 1'b0;
				foreach (tbl_seen[i]) tbl_seen[i] = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic push_request(logic [1:0] op, logic [1:0] mode,
			logic [srat_pkg::ADDR_W-1:0] a, logic [srat_pkg::REC_W-1:0] r);
		pending_t p;
		p = '{PEND_REQ, op, mode, a, r, srat_pkg::REG_AGE_START, 8'd0};
		pending.push_back(p);
	endtask

	task automatic push_write(logic [1:0] idx, logic [7:0] data);
		pending_t p;
		p = '{PEND_CFG, srat_pkg::OP_BEGIN, srat_pkg::MODE_PASS, '0, '0, idx, data};
		pending.push_back(p);
	endtask

	// Append one framed scan of n results. Passive scans mostly revisit known
	// access points; active scans sometimes repeat one to leave duplicates.
	task automatic push_scan(logic [1:0] mode, int n);
		logic [srat_pkg::ADDR_W-1:0] a;
		push_request(srat_pkg::OP_BEGIN, mode, rand_addr(), $urandom());
		for (int k = 0; k < n; k++) begin
			if (addr_pool.size() > 0 && $urandom_range(0, 99) < 60)
				a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
			else
				a = rand_addr();
			addr_pool.push_back(a);
			if (addr_pool.size() > 48)
				void'(addr_pool.pop_front());
			push_request(srat_pkg::OP_RESULT, mode, a, $urandom());
		end
		push_request(srat_pkg::OP_END, mode, rand_addr(), $urandom());
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Drive at the falling edge: hold a request until it is taken, then pick the
	// next one. Register writes and pauses wait until the block has gone quiet.
	always @(negedge clk) begin
		if (arst_n) begin : drive
			logic     nxt_start;
			logic     nxt_cfg;
			pending_t p;
			nxt_start = start;
			nxt_cfg = cfg_valid;
			if (req_taken) begin
				nxt_start = 1'b0;
				req_taken = 0;
			end
			if (cfg_taken) begin
				nxt_cfg = 1'b0;
				cfg_taken = 0;
			end
			if (expected_reports.size() == 0 && !busy && !start)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!nxt_start && !nxt_cfg && pending.size() > 0) begin
				p = pending[0];
				if (p.tag == PEND_REQ) begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						void'(pending.pop_front());
						nxt_start = 1'b1;
						opcode <= p.op;
						scan_mode <= p.mode;
						bssid <= p.addr;
						record_word <= p.rec;
						burst_left--;
						if (burst_left <= 0) begin
							burst_left = $urandom_range(1, 40);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						end
					end
				end else if (quiet_cycles >= 8) begin
					// Idle long enough: the last end of scan has fully finished.
					void'(pending.pop_front());
					if (p.tag == PEND_CFG) begin
						nxt_cfg = 1'b1;
						cfg_index <= p.ridx;
						cfg_data <= p.rdata;
					end
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// Monitor at the rising edge: check results first, then predict from
	// whatever the block took in this cycle.
	always @(posedge clk) begin
		if (arst_n) begin : watch
			scan_report_t got;
			scan_report_t want;
			if (result_valid) begin
				got = '{kind, out_bssid, out_record, merged_count, insert_dropped, last};
				reports_checked++;
				if (kind == srat_pkg::KIND_REPLAY)
					replays_seen++;
				else if (insert_dropped)
					drops_seen++;
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d bssid %h rec %h count %0d drop %0d last %0d",
							got.kind, got.addr, got.rec, got.count, got.drop, got.last);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch exp: kind %0d bssid %h rec %h count %0d drop %0d last %0d",
								want.kind, want.addr, want.rec, want.count, want.drop, want.last);
							$display("         got: kind %0d bssid %h rec %h count %0d drop %0d last %0d",
								got.kind, got.addr, got.rec, got.count, got.drop, got.last);
						end
					end
				end
			end
			if (start && !busy) begin
				apply_scan_request(opcode, scan_mode, bssid, record_word);
				requests_taken++;
				req_taken = 1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == srat_pkg::REG_AGE_START)
					age_start_reg = cfg_data[srat_pkg::AGE_W-1:0];
				else if (cfg_index == srat_pkg::REG_RESULT_LIMIT)
					limit_reg = cfg_data;
				cfg_taken = 1;
			end
		end
	end

	// Hard limit on the run.
	initial begin
		#2ms;
		$display("timeout with %0d requests pending", pending.size());
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		logic [srat_pkg::ADDR_W-1:0] a;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = srat_pkg::OP_BEGIN;
		scan_mode = srat_pkg::MODE_PASS;
		bssid = '0;
		record_word = '0;
		cfg_valid = 1'b0;
		cfg_index = srat_pkg::REG_AGE_START;
		cfg_data = 8'd0;
		tbl_occ = 0;
		cur_mode = srat_pkg::MODE_PASS;
		item_count = 0;
		drop_pending = 1'b0;
		age_start_reg = 4'd4;
		limit_reg = 8'd32;
		foreach (tbl_seen[i]) begin
			tbl_seen[i] = 1'b0;
			tbl_age[i] = '0;
		end
		mismatches = 0;
		reports_checked = 0;
		replays_seen = 0;
		drops_seen = 0;
		requests_taken = 0;
		burst_left = 8;
		gap_left = 0;
		quiet_cycles = 0;

		// Directed: field extremes, refresh, aging and replay, odd codes,
		// duplicates from an active scan, and items outside a frame.
		a = rand_addr();
		push_request(srat_pkg::OP_BEGIN, srat_pkg::MODE_PASSIVE, '0, '0);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_PASSIVE, '0, '0);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_PASSIVE, '1, '1);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_PASSIVE, '0, 32'h5a5a_a5a5);
		push_request(srat_pkg::OP_END, srat_pkg::MODE_PASSIVE, '1, '1);
		push_request(srat_pkg::OP_BEGIN, srat_pkg::MODE_PASSIVE, '0, '0);
		push_request(srat_pkg::OP_END, srat_pkg::MODE_PASSIVE, '0, '0);
		push_request(OP_SPARE, MODE_SPARE, '1, '1);
		push_request(srat_pkg::OP_BEGIN, MODE_SPARE, '0, '0);
		push_request(srat_pkg::OP_RESULT, MODE_SPARE, a, 32'h1);
		push_request(srat_pkg::OP_END, MODE_SPARE, '0, '0);
		push_request(srat_pkg::OP_BEGIN, srat_pkg::MODE_ACTIVE, '0, '0);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_ACTIVE, a, 32'h11);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_ACTIVE, '1, 32'h22);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_ACTIVE, a, 32'h33);
		push_request(srat_pkg::OP_END, srat_pkg::MODE_ACTIVE, '0, '0);
		push_request(srat_pkg::OP_BEGIN, srat_pkg::MODE_PASSIVE, '0, '0);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_PASSIVE, '1, 32'h44);
		push_request(srat_pkg::OP_END, srat_pkg::MODE_PASSIVE, '0, '0);
		push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_PASSIVE, rand_addr(), 32'h55);
		push_request(srat_pkg::OP_END, srat_pkg::MODE_PASSIVE, '0, '0);

		// Overflow: fill the table actively past its depth, then try to add
		// fresh access points passively.
		push_write(srat_pkg::REG_RESULT_LIMIT, 8'd255);
		push_scan(srat_pkg::MODE_ACTIVE, srat_pkg::TABLE_DEPTH + 3);
		push_request(srat_pkg::OP_BEGIN, srat_pkg::MODE_PASSIVE, '0, '0);
		for (int k = 0; k < 4; k++)
			push_request(srat_pkg::OP_RESULT, srat_pkg::MODE_PASSIVE, rand_addr(), $urandom());
		push_request(srat_pkg::OP_END, srat_pkg::MODE_PASSIVE, '0, '0);
		pending.push_back(pending_t'{PEND_DRAIN, srat_pkg::OP_BEGIN, srat_pkg::MODE_PASS,
			'0, '0, srat_pkg::REG_AGE_START, 8'd0});

		// Random phases, each with its own register setting, extremes first.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					push_write(srat_pkg::REG_AGE_START, 8'd1);
					push_write(srat_pkg::REG_RESULT_LIMIT, 8'd0);
				end
				1: begin
					push_write(srat_pkg::REG_AGE_START, 8'd15);
					push_write(srat_pkg::REG_RESULT_LIMIT, 8'd255);
				end
				2: begin
					push_write(srat_pkg::REG_AGE_START, 8'd2);
					push_write(srat_pkg::REG_RESULT_LIMIT, 8'd3);
				end
				default: begin
					push_write(srat_pkg::REG_AGE_START, 8'($urandom_range(1, 15)));
					push_write(srat_pkg::REG_RESULT_LIMIT, 8'(($urandom_range(0, 3) == 0)
						? $urandom_range(0, 255) : $urandom_range(0, 40)));
				end
			endcase
			for (int s = 0; s < 8; s++) begin
				case ($urandom_range(0, 9)) inside
					[0:4]: push_scan(srat_pkg::MODE_PASSIVE, $urandom_range(0, 10));
					[5:6]: push_scan(srat_pkg::MODE_ACTIVE, $urandom_range(0, 12));
					7: push_scan(srat_pkg::MODE_PASS, $urandom_range(0, 5));
					default: begin
						// Noise: stray codes, unframed results and lone ends.
						push_request(OP_SPARE, 2'($urandom()), rand_addr(), $urandom());
						push_request(srat_pkg::OP_RESULT, 2'($urandom()), rand_addr(),
							$urandom());
						push_request(srat_pkg::OP_END, 2'($urandom()), rand_addr(), $urandom());
						push_request(srat_pkg::OP_BEGIN, MODE_SPARE, rand_addr(), $urandom());
					end
				endcase
			end
		end
		push_write(srat_pkg::REG_AGE_START, 8'd4);
		push_write(srat_pkg::REG_RESULT_LIMIT, 8'd32);
		push_scan(srat_pkg::MODE_PASSIVE, 4);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() > 0 || start || cfg_valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (srat_pkg::TABLE_DEPTH + 10) @(posedge clk);

		mismatches += expected_reports.size();
		$display("run: %0d requests taken, %0d results checked", requests_taken, reports_checked);
		$display("run: %0d replayed entries, %0d summaries with dropped inserts",
			replays_seen, drops_seen);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
